### design/dma_rbpc_pkg.sv
`default_nettype none
package dma_rbpc_pkg;

  // Fixed widths of the item fields and the position registers.
  localparam int POS_W = 32;
  localparam int CNT_W = 17;
  localparam int CMD_W = 3;
  localparam int LOG_W = 5;
  localparam int ESC_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;

  localparam int DEFAULT_MAX_RING_LOG2 = 16;
  localparam int MIN_RING_LOG2 = 4;

  // Command codes carried by an input item.
  localparam logic [CMD_W-1:0] CMD_ACQUIRE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SYNC     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DMA_DONE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FLUSH    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TX_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_LOG2    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_SIZE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HANDLER_EN   = 3'd4;

  // Element size codes.
  localparam logic [ESC_W-1:0] ESC_WORD = 2'd2;

  localparam logic [LOG_W-1:0] RESET_RING_LOG2 = 5'd8;

  // Step commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic update;
    logic space;
    logic result;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

### design/dma_rbpc_ctrl.sv
`default_nettype none
module dma_rbpc_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire                     out_stall,
  output dma_rbpc_pkg::ctrl_cmd_t cmd
);
  import dma_rbpc_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_UPDATE = 2'd1;
  localparam logic [1:0] S_SPACE  = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       accept;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load_item = 1'b1;
          state_next    = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_SPACE;
      end
      S_SPACE: begin
        cmd.space  = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.result     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

### design/dma_rbpc_dp.sv
`default_nettype none
module dma_rbpc_dp #(
  parameter int MAX_RING_LOG2 = dma_rbpc_pkg::DEFAULT_MAX_RING_LOG2
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  dma_rbpc_pkg::ctrl_cmd_t               cmd,
  input  wire                                   cfg_write,
  input  wire  [dma_rbpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [dma_rbpc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire  [dma_rbpc_pkg::CMD_W-1:0]        command,
  input  wire  [dma_rbpc_pkg::CNT_W-1:0]        amount,
  input  wire  [dma_rbpc_pkg::CNT_W-1:0]        remaining_count,
  output logic [MAX_RING_LOG2-1:0]              window_index,
  output logic [MAX_RING_LOG2:0]                window_length,
  output logic                                  dma_start,
  output logic [dma_rbpc_pkg::CNT_W-1:0]        dma_count,
  output logic                                  call_handler
);
  import dma_rbpc_pkg::*;

  // Configuration registers.
  logic             tx_mode;
  logic [LOG_W-1:0] ring_size_log2;
  logic [CNT_W-1:0] max_chunk_bytes;
  logic [ESC_W-1:0] element_size_code;
  logic             handler_enabled;

  // Ring state.
  logic [POS_W-1:0] read_position;
  logic [POS_W-1:0] write_position;
  logic [CNT_W-1:0] inflight_count;
  logic [POS_W-1:0] read_position_next;
  logic [POS_W-1:0] write_position_next;
  logic [CNT_W-1:0] inflight_count_next;

  // Latched item.
  logic [CMD_W-1:0] command_r;
  logic [CNT_W-1:0] amount_r;
  logic [CNT_W-1:0] remaining_r;

  // Occupancy registered between the update and result steps.
  logic [POS_W-1:0]         fill_r;
  logic [POS_W-1:0]         avail_r;
  logic [MAX_RING_LOG2-1:0] idx_r;

  logic [LOG_W-1:0] lg;
  logic [1:0]       shamt;
  logic [POS_W-1:0] size;
  logic [POS_W-1:0] delta;
  logic [POS_W-1:0] cap;
  logic [POS_W-1:0] chunk_space;
  logic [POS_W-1:0] chunk_min;
  logic [POS_W-1:0] chunk_full;
  logic [CNT_W-1:0] chunk;
  logic [POS_W-1:0] fill_now;
  logic [POS_W-1:0] idx_full;
  logic [POS_W-1:0] room;
  logic [POS_W-1:0] acq_count;
  logic [POS_W-1:0] acq_min;

  logic [MAX_RING_LOG2-1:0] res_index;
  logic [MAX_RING_LOG2:0]   res_length;
  logic                     res_start;
  logic [CNT_W-1:0]         res_count;
  logic                     res_handler;

  always_comb begin
    if (ring_size_log2 < LOG_W'(MIN_RING_LOG2)) begin
      lg = LOG_W'(MIN_RING_LOG2);
    end else if (ring_size_log2 > LOG_W'(MAX_RING_LOG2)) begin
      lg = LOG_W'(MAX_RING_LOG2);
    end else begin
      lg = ring_size_log2;
    end
    shamt = (element_size_code > ESC_WORD) ? ESC_WORD : element_size_code;
  end

  assign size  = POS_W'(1) << lg;
  assign delta = (POS_W'(inflight_count) - POS_W'(remaining_r)) << shamt;

  // Position update step.
  always_comb begin
    read_position_next  = read_position;
    write_position_next = write_position;
    inflight_count_next = inflight_count;
    unique case (command_r)
      CMD_RELEASE: begin
        if (tx_mode) begin
          write_position_next = write_position + POS_W'(amount_r);
        end else begin
          read_position_next = read_position + POS_W'(amount_r);
        end
      end
      CMD_SYNC: begin
        if (inflight_count != '0) begin
          if (tx_mode) read_position_next = read_position + delta;
          else write_position_next = write_position + delta;
          inflight_count_next = remaining_r;
        end
      end
      CMD_DMA_DONE: begin
        if (tx_mode) read_position_next = read_position + delta;
        else write_position_next = write_position + delta;
      end
      CMD_CLEAR: begin
        read_position_next  = '0;
        write_position_next = '0;
        inflight_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign fill_now = write_position - read_position;
  assign idx_full = (tx_mode ? write_position : read_position) & (size - POS_W'(1));

  // Result step: chunk size and acquire window from registered occupancy.
  assign cap         = (max_chunk_bytes != '0) ? POS_W'(max_chunk_bytes) : (size >> 1);
  assign chunk_space = tx_mode ? fill_r : avail_r;
  assign chunk_min   = (chunk_space > cap) ? cap : chunk_space;
  assign chunk_full  = chunk_min >> shamt;
  assign chunk       = chunk_full[CNT_W-1:0];
  assign room        = size - POS_W'(idx_r);
  assign acq_count   = tx_mode ? avail_r : fill_r;
  assign acq_min     = (acq_count > room) ? room : acq_count;

  always_comb begin
    res_index   = '0;
    res_length  = '0;
    res_start   = 1'b0;
    res_count   = '0;
    res_handler = 1'b0;
    unique case (command_r)
      CMD_ACQUIRE: begin
        res_index  = idx_r;
        res_length = acq_min[MAX_RING_LOG2:0];
      end
      CMD_DMA_DONE: begin
        if (chunk != '0) begin
          res_start = 1'b1;
          res_count = chunk;
        end else begin
          res_handler = handler_enabled;
        end
      end
      CMD_FLUSH, CMD_CLEAR: begin
        if (inflight_count == '0 && chunk != '0) begin
          res_start = 1'b1;
          res_count = chunk;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_mode           <= 1'b0;
      ring_size_log2    <= RESET_RING_LOG2;
      max_chunk_bytes   <= '0;
      element_size_code <= '0;
      handler_enabled   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TX_MODE:    tx_mode           <= cfg_data[0];
        CFG_RING_LOG2:  ring_size_log2    <= cfg_data[LOG_W-1:0];
        CFG_MAX_CHUNK:  max_chunk_bytes   <= cfg_data[CNT_W-1:0];
        CFG_ELEM_SIZE:  element_size_code <= cfg_data[ESC_W-1:0];
        CFG_HANDLER_EN: handler_enabled   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_position  <= '0;
      write_position <= '0;
      inflight_count <= '0;
    end else if (cmd.update) begin
      read_position  <= read_position_next;
      write_position <= write_position_next;
      inflight_count <= inflight_count_next;
    end else if (cmd.result && (res_start || command_r == CMD_DMA_DONE)) begin
      // A completion always takes the new chunk, zero when the DMA goes idle.
      inflight_count <= res_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      command_r   <= command;
      amount_r    <= amount;
      remaining_r <= remaining_count;
    end
    if (cmd.space) begin
      fill_r  <= fill_now;
      avail_r <= size - fill_now;
      idx_r   <= idx_full[MAX_RING_LOG2-1:0];
    end
    if (cmd.result) begin
      window_index  <= res_index;
      window_length <= res_length;
      dma_start     <= res_start;
      dma_count     <= res_count;
      call_handler  <= res_handler;
    end
  end

endmodule
`default_nettype wire

### design/dma_ring_buffer_pointer_control.sv
`default_nettype none
// Pointer controller for a power-of-two byte ring shared between software and a
// DMA channel. It keeps free-running 32-bit read and write byte positions and
// the element count of the DMA chunk in flight, and answers each command item
// with exactly one result item: acquire returns the contiguous window software
// may touch, release advances the software-side position, sync and dma_done
// fold in DMA progress from the channel's remaining count, and dma_done, flush
// and clear may ask for a new DMA chunk (dma_start with dma_count) or, when the
// DMA goes idle after a completion, raise call_handler if enabled. After
// reset the DMA is idle and software must issue flush or clear to start it.
// Configuration is written through the cfg port, which is always ready, and
// must only change while no item is in progress. The controller takes no new
// item until the current one has passed through its steps: in order, the
// accepting edge latches the item, the update step applies the position
// update adder, the space step registers ring occupancy, and the result step
// loads the result from the chunk limit and window compare into the output
// register. The output register lets the next item be accepted while a
// result still waits to be taken; a stalled output holds the controller in its
// result step until the register frees up.
module dma_ring_buffer_pointer_control #(
  parameter int MAX_RING_LOG2 = dma_rbpc_pkg::DEFAULT_MAX_RING_LOG2
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [dma_rbpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [dma_rbpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  [dma_rbpc_pkg::CMD_W-1:0]       command,
  input  wire  [dma_rbpc_pkg::CNT_W-1:0]       amount,
  input  wire  [dma_rbpc_pkg::CNT_W-1:0]       remaining_count,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [MAX_RING_LOG2-1:0]             window_index,
  output logic [MAX_RING_LOG2:0]               window_length,
  output logic                                 dma_start,
  output logic [dma_rbpc_pkg::CNT_W-1:0]       dma_count,
  output logic                                 call_handler
);
  import dma_rbpc_pkg::*;

  ctrl_cmd_t cmd;

  // Every register write is taken as it is offered, so the port never pushes back.
  assign cfg_ready = 1'b1;

  // The controller sequences the steps of one item and owns both handshakes.
  dma_rbpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The datapath holds configuration, ring positions and the result register.
  dma_rbpc_dp #(
    .MAX_RING_LOG2 (MAX_RING_LOG2)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .command         (command),
    .amount          (amount),
    .remaining_count (remaining_count),
    .window_index    (window_index),
    .window_length   (window_length),
    .dma_start       (dma_start),
    .dma_count       (dma_count),
    .call_handler    (call_handler)
  );

endmodule
`default_nettype wire

### verif/tb_top.sv
`default_nettype none
// Testbench for the DMA ring-buffer pointer controller.
//
// The bench keeps its own copy of the ring state: read and write byte
// positions, the element count of the chunk in flight, and the five
// configuration registers. Every command item is run through that copy at the
// moment the block accepts it. The result it yields is queued, and the checker
// compares each result item the block hands out, field by field, against the
// oldest queued entry.
//
// The stimulus comes in named tests that the initial block below calls in
// turn. Two short directed tests come first, one in receive mode under the
// reset settings and one in transmit mode under extreme settings, and they
// walk through the corner cases. Random phases follow, each under its own
// register settings. Their items mostly follow a plausible software and DMA
// conversation: releases stay within the ring, and sync and dma_done report
// remaining counts no larger than the chunk in flight. A share of noise items
// mixes in reserved commands and out-of-range fields. A back-pressure test
// then holds the output off long enough for the block to fill up and stall its
// input. The run ends with two phases in which neither side idles.
module tb_top;
  import dma_rbpc_pkg::*;

  localparam int MAX_RING_LOG2 = DEFAULT_MAX_RING_LOG2;
  localparam int LIMIT_CYCLES = 200000;
  // Four pipeline steps plus the output register, with some margin.
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int PHASE_ITEMS = 31;

  // Command codes that the block does not define; they must yield an all-zero
  // result and leave the state alone.
  localparam logic [CMD_W-1:0] CMD_RESERVED_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RESERVED_B = 3'd7;

  typedef struct packed {
    logic [MAX_RING_LOG2-1:0] index;
    logic [MAX_RING_LOG2:0]   length;
    logic                     start;
    logic [CNT_W-1:0]         count;
    logic                     handler;
  } ring_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CMD_W-1:0] command = CMD_ACQUIRE;
  logic [CNT_W-1:0] amount = '0;
  logic [CNT_W-1:0] remaining_count = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [MAX_RING_LOG2-1:0] window_index;
  logic [MAX_RING_LOG2:0]   window_length;
  logic                     dma_start;
  logic [CNT_W-1:0]         dma_count;
  logic                     call_handler;

  dma_ring_buffer_pointer_control #(
    .MAX_RING_LOG2(MAX_RING_LOG2)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .amount(amount),
    .remaining_count(remaining_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .window_index(window_index),
    .window_length(window_length),
    .dma_start(dma_start),
    .dma_count(dma_count),
    .call_handler(call_handler)
  );

  always #10 clk = ~clk;

  // Shadow copy of the registers, mirroring every accepted configuration write.
  logic             shadow_tx;
  logic [LOG_W-1:0] shadow_ring_log2;
  logic [CNT_W-1:0] shadow_max_chunk;
  logic [ESC_W-1:0] shadow_elem;
  logic             shadow_handler_en;

  // Shadow ring state. The positions run freely modulo 2^32.
  logic [POS_W-1:0] read_pos;
  logic [POS_W-1:0] write_pos;
  logic [POS_W-1:0] chunk_inflight;

  // Results owed by the block, oldest first.
  ring_result_t pointer_results[$];

  int  error_count = 0;
  int  cycle_count = 0;
  bit  sender_idle_on = 1'b1;
  bit  receiver_idle_on = 1'b1;
  // Set by a test to ask the receiver for one long hold-off; the receiver
  // clears it when it takes the request.
  bit  hold_req = 1'b0;

  initial begin
    shadow_tx = 1'b0;
    shadow_ring_log2 = RESET_RING_LOG2;
    shadow_max_chunk = '0;
    shadow_elem = '0;
    shadow_handler_en = 1'b0;
    read_pos = '0;
    write_pos = '0;
    chunk_inflight = '0;
  end

  // Ring size in bytes, with the log2 setting clamped to the supported range.
  function automatic logic [POS_W-1:0] ring_bytes();
    logic [LOG_W-1:0] lg;
    lg = shadow_ring_log2;
    if (lg < LOG_W'(MIN_RING_LOG2)) lg = LOG_W'(MIN_RING_LOG2);
    if (lg > LOG_W'(MAX_RING_LOG2)) lg = LOG_W'(MAX_RING_LOG2);
    return 32'd1 << lg;
  endfunction

  // Bytes-per-element shift; the unused code three counts as a word.
  function automatic logic [ESC_W-1:0] elem_shift();
    return (shadow_elem > ESC_WORD) ? ESC_WORD : shadow_elem;
  endfunction

  // Elements in the next chunk: free space (receive) or filled space
  // (transmit), capped, then scaled down to elements.
  function automatic logic [CNT_W-1:0] chunk_elements();
    logic [POS_W-1:0] size;
    logic [POS_W-1:0] space;
    logic [POS_W-1:0] cap;
    size = ring_bytes();
    space = write_pos - read_pos;
    cap = (shadow_max_chunk != 0) ? POS_W'(shadow_max_chunk) : (size >> 1);
    if (!shadow_tx) space = size - space;
    if (space > cap) space = cap;
    space = space >> elem_shift();
    return space[CNT_W-1:0];
  endfunction

  // Moves the DMA-side position by the elements done so far.
  function automatic void fold_progress(input logic [CNT_W-1:0] rem);
    logic [POS_W-1:0] delta;
    delta = (chunk_inflight - POS_W'(rem)) << elem_shift();
    if (shadow_tx) read_pos += delta;
    else write_pos += delta;
  endfunction

  // Applies one command to the shadow state and returns the result it owes.
  function automatic ring_result_t ring_step(input logic [CMD_W-1:0] cmd,
                                             input logic [CNT_W-1:0] amt,
                                             input logic [CNT_W-1:0] rem);
    ring_result_t r;
    logic [POS_W-1:0] size;
    logic [POS_W-1:0] idx;
    logic [POS_W-1:0] cnt;
    logic [POS_W-1:0] room;
    logic [CNT_W-1:0] n;
    r = '0;
    case (cmd)
      CMD_ACQUIRE: begin
        size = ring_bytes();
        idx = read_pos;
        cnt = write_pos - read_pos;
        if (shadow_tx) begin
          idx = write_pos;
          cnt = size - cnt;
        end
        idx &= size - 1;
        room = size - idx;
        if (cnt > room) cnt = room;
        r.index = idx[MAX_RING_LOG2-1:0];
        r.length = cnt[MAX_RING_LOG2:0];
      end
      CMD_RELEASE: begin
        if (shadow_tx) write_pos += POS_W'(amt);
        else read_pos += POS_W'(amt);
      end
      CMD_SYNC: begin
        if (chunk_inflight != 0) begin
          fold_progress(rem);
          chunk_inflight = POS_W'(rem);
        end
      end
      CMD_DMA_DONE: begin
        fold_progress(rem);
        n = chunk_elements();
        chunk_inflight = POS_W'(n);
        if (n != 0) begin
          r.start = 1'b1;
          r.count = n;
        end else if (shadow_handler_en) begin
          r.handler = 1'b1;
        end
      end
      CMD_FLUSH, CMD_CLEAR: begin
        if (cmd == CMD_CLEAR) begin
          read_pos = '0;
          write_pos = '0;
          chunk_inflight = '0;
        end
        // A flush only starts the DMA when nothing is in flight.
        if (chunk_inflight == 0) begin
          n = chunk_elements();
          if (n != 0) begin
            chunk_inflight = POS_W'(n);
            r.start = 1'b1;
            r.count = n;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_failure(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Offers one item, possibly after a random gap, and records its expected
  // result once the block has taken it. Valid stays high on return so that
  // back-to-back items keep the input busy.
  task automatic send_item(input logic [CMD_W-1:0] cmd,
                           input logic [CNT_W-1:0] amt,
                           input logic [CNT_W-1:0] rem);
    int gap;
    @(negedge clk);
    if (sender_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    amount <= amt;
    remaining_count <= rem;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pointer_results.push_back(ring_step(cmd, amt, rem));
  endtask

  // Stops offering items and waits until every owed result has come out, then
  // lets the pipeline settle.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pointer_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TX_MODE:    shadow_tx = value[0];
      CFG_RING_LOG2:  shadow_ring_log2 = value[LOG_W-1:0];
      CFG_MAX_CHUNK:  shadow_max_chunk = value[CNT_W-1:0];
      CFG_ELEM_SIZE:  shadow_elem = value[ESC_W-1:0];
      CFG_HANDLER_EN: shadow_handler_en = value[0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure_ring(input logic tx, input logic [LOG_W-1:0] lg,
                                input logic [CNT_W-1:0] cap, input logic [ESC_W-1:0] esc,
                                input logic hen);
    write_reg(CFG_TX_MODE, CFG_DATA_W'(tx));
    write_reg(CFG_RING_LOG2, CFG_DATA_W'(lg));
    write_reg(CFG_MAX_CHUNK, CFG_DATA_W'(cap));
    write_reg(CFG_ELEM_SIZE, CFG_DATA_W'(esc));
    write_reg(CFG_HANDLER_EN, CFG_DATA_W'(hen));
  endtask

  // A count field value: usually within the documented range, sometimes any
  // 17-bit pattern.
  function automatic logic [CNT_W-1:0] random_count();
    if ($urandom_range(0, 3) == 0) return CNT_W'($urandom());
    return CNT_W'($urandom_range(0, 65536));
  endfunction

  // Sends one item of a plausible conversation, judged from the shadow state,
  // or now and then a noise item.
  task automatic send_session_item();
    logic [POS_W-1:0] size;
    logic [POS_W-1:0] fill;
    logic [POS_W-1:0] avail;
    logic [CNT_W-1:0] rem;
    int pick;
    size = ring_bytes();
    fill = write_pos - read_pos;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      send_item(CMD_W'($urandom_range(0, 7)), random_count(), random_count());
    end else if (pick < 30) begin
      send_item(CMD_ACQUIRE, random_count(), random_count());
    end else if (pick < 50) begin
      // Software hands back what it has written (transmit) or read (receive).
      if (fill > size) avail = size;
      else avail = shadow_tx ? size - fill : fill;
      send_item(CMD_RELEASE, CNT_W'($urandom_range(0, avail)), random_count());
    end else if (pick < 62) begin
      rem = (chunk_inflight != 0) ? CNT_W'($urandom_range(0, chunk_inflight)) :
                                    random_count();
      send_item(CMD_SYNC, random_count(), rem);
    end else if (pick < 86) begin
      if (chunk_inflight != 0) begin
        rem = ($urandom_range(0, 3) != 0) ? '0 : CNT_W'($urandom_range(0, chunk_inflight));
        send_item(CMD_DMA_DONE, random_count(), rem);
      end else begin
        send_item(CMD_FLUSH, random_count(), random_count());
      end
    end else if (pick < 96) begin
      send_item(CMD_FLUSH, random_count(), random_count());
    end else begin
      send_item(CMD_CLEAR, random_count(), random_count());
    end
  endtask

  // One phase of random traffic under the given settings, started by a clear.
  task automatic run_phase(input logic tx, input logic [LOG_W-1:0] lg,
                           input logic [CNT_W-1:0] cap, input logic [ESC_W-1:0] esc,
                           input logic hen);
    wait_drained();
    configure_ring(tx, lg, cap, esc, hen);
    send_item(CMD_CLEAR, random_count(), random_count());
    repeat (PHASE_ITEMS) send_session_item();
  endtask

  // Receive mode under the reset settings: 256-byte ring, chunk capped at half
  // the ring, byte elements, no handler.
  task automatic test_rx_directed();
    send_item(CMD_ACQUIRE, '0, '0);              // empty ring, nothing to read
    send_item(CMD_SYNC, '0, 17'd5);              // sync while idle does nothing
    send_item(CMD_FLUSH, '0, '0);                // first chunk starts
    send_item(CMD_FLUSH, '0, '0);                // busy, so no new start
    send_item(CMD_SYNC, '0, 17'd100);            // 28 bytes have arrived
    send_item(CMD_ACQUIRE, '0, '0);
    send_item(CMD_RELEASE, 17'd20, '0);
    send_item(CMD_DMA_DONE, '0, '0);             // chunk done, next one starts
    send_item(CMD_RESERVED_A, 17'd65536, 17'd65536);
    send_item(CMD_RESERVED_B, '1, '1);
    send_item(CMD_RELEASE, 17'd65536, '0);       // software releases far too much
    send_item(CMD_ACQUIRE, '0, '0);
    send_item(CMD_DMA_DONE, '0, 17'd65536);      // remaining above what is in flight
    send_item(CMD_ACQUIRE, '1, '1);
    send_item(CMD_CLEAR, '0, '0);
    send_item(CMD_DMA_DONE, '1, '0);
  endtask

  // Transmit mode at the small extreme: clamped 16-byte ring, a cap above the
  // ring size, element code three, handler enabled.
  task automatic test_tx_directed();
    wait_drained();
    configure_ring(1'b1, 5'd0, 17'd65536, 2'd3, 1'b1);
    send_item(CMD_CLEAR, '0, '0);                // nothing to send, no start
    send_item(CMD_DMA_DONE, '0, '0);             // idle completion raises the handler
    send_item(CMD_RELEASE, 17'd16, '0);          // software fills the whole ring
    send_item(CMD_ACQUIRE, '0, '0);              // no room left
    send_item(CMD_FLUSH, '0, '0);                // four words go out
    send_item(CMD_SYNC, '0, 17'd3);
    send_item(CMD_DMA_DONE, '0, 17'd1);          // early completion folds in as given
    send_item(CMD_DMA_DONE, '0, '0);             // last word done, the idle DMA raises the handler
    send_item(CMD_ACQUIRE, '0, '0);
    send_item(CMD_RELEASE, '1, '0);
    send_item(CMD_ACQUIRE, '0, '0);
  endtask

  // Random traffic over a spread of settings, the extremes among them, with
  // idling switched on and off per phase.
  task automatic test_random_phases();
    logic [LOG_W-1:0] lg_choice[8] = '{5'd8, 5'd16, 5'd4, 5'd16, 5'd31, 5'd0, 5'd12, 5'd3};
    logic [CNT_W-1:0] cap_choice[8] = '{17'd0, 17'd65536, 17'd0, 17'd0, 17'd1, '1, 17'd1000,
                                        17'd6};
    for (int p = 0; p < 10; p++) begin
      sender_idle_on = ($urandom_range(0, 3) != 0);
      receiver_idle_on = ($urandom_range(0, 3) != 0);
      if (p < 8) begin
        run_phase(p[0], lg_choice[p], cap_choice[p], ESC_W'(p % 4), p[1]);
      end else begin
        run_phase(1'($urandom()), LOG_W'($urandom()), random_count(),
                  ESC_W'($urandom()), 1'($urandom()));
      end
      // Halfway through, the sender waits for every owed result once.
      if (p == 4) wait_drained();
    end
  endtask

  // The receiver holds off long enough for the block to fill and stall its
  // input while the sender keeps offering items; then the sender waits for
  // every owed result.
  task automatic test_output_holdoff();
    wait_drained();
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    hold_req = 1'b1;
    repeat (24) send_session_item();
    wait_drained();
  endtask

  // Closing stretch with both sides running at full rate.
  task automatic test_final_no_idle();
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    run_phase(1'b0, 5'd10, 17'd200, 2'd1, 1'b1);
    run_phase(1'b1, 5'd6, 17'd0, 2'd0, 1'b0);
  endtask

  // Receiver side: random stall bursts, plus one long hold-off on request,
  // counted here.
  initial begin : receiver
    int burst;
    int hold;
    burst = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold = LONG_HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every result item the block hands out is matched against the oldest
  // expectation, one field at a time.
  always @(posedge clk) begin : check_results
    ring_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pointer_results.size() == 0) begin
        report_failure("result item with no command waiting for it");
      end else begin
        want = pointer_results.pop_front();
        if (window_index !== want.index)
          report_failure($sformatf("window_index 0x%0h, expected 0x%0h",
                                   window_index, want.index));
        if (window_length !== want.length)
          report_failure($sformatf("window_length 0x%0h, expected 0x%0h",
                                   window_length, want.length));
        if (dma_start !== want.start)
          report_failure($sformatf("dma_start %b, expected %b", dma_start, want.start));
        if (dma_count !== want.count)
          report_failure($sformatf("dma_count 0x%0h, expected 0x%0h",
                                   dma_count, want.count));
        if (call_handler !== want.handler)
          report_failure($sformatf("call_handler %b, expected %b",
                                   call_handler, want.handler));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pointer_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_rx_directed();
    test_tx_directed();
    test_random_phases();
    test_output_holdoff();
    test_final_no_idle();
    wait_drained();
    if (error_count == 0 && pointer_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
design/dma_rbpc_pkg.sv
design/dma_rbpc_ctrl.sv
design/dma_rbpc_dp.sv
design/dma_ring_buffer_pointer_control.sv
verif/tb_top.sv
